// ----- src/hbms_pkg.sv -----
// Package for the heartbeat mask supervisor: widths, item kind codes,
// the component mask constant and the item and result structs.
// No dependencies.
package hbms_pkg;

    localparam int MASK_W         = 32;
    localparam int CNT_W          = 16;
    localparam int COMPONENT_BITS = 32;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int TDATA_OUT_W    = 40;

    localparam logic [CNT_W-1:0] CHECK_PERIOD_RST = 16'd600;
    localparam logic [CNT_W-1:0] FEED_PERIOD_RST  = 16'd10;

    // Components at or above COMPONENT_BITS are ignored everywhere.
    localparam logic [MASK_W-1:0] COMP_MASK =
        (COMPONENT_BITS >= MASK_W) ? {MASK_W{1'b1}} :
        ((MASK_W'(1) << COMPONENT_BITS) - MASK_W'(1));

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_REGISTER = 2'd1,
        KIND_REPORT   = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    // Register select taken from paddr[2].
    typedef enum logic {
        REG_CHECK_PERIOD = 1'b0,
        REG_FEED_PERIOD  = 1'b1
    } reg_sel_t;

    typedef struct packed {
        kind_t             kind;
        logic [MASK_W-1:0] component_mask;
    } item_t;

    typedef struct packed {
        logic              feed_pulse;
        logic              check_done;
        logic              check_failed;
        logic [MASK_W-1:0] missing_mask;
        logic              emergency;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] check_period;
        logic [CNT_W-1:0] feed_period;
    } cfg_t;

endpackage

// ----- src/heartbeat_mask_supervisor.sv -----
// Heartbeat mask supervisor top level: input item register, supervisor
// core, result register and APB configuration. Depends on hbms_pkg,
// hbms_cfg and hbms_core.
//
// Use: each input item carries a kind on s_tuser (tick, register
// components, report heartbeat, raise error) and a component mask on
// s_tdata. Every item gives exactly one result on m_tdata: feed pulse,
// check done, check failed, missing mask and the emergency latch.
// An accepted item is held in the input register and then in the result
// register, which drives m_tvalid. Throughput is one item per cycle while
// the receiver takes results; the state update for an item happens as
// it moves from the input register to the result register. When the
// receiver stalls, the result register holds and the input register
// fills; s_tready drops only when both are full. Reset (aresetn low,
// synchronous) empties both registers, clears the sets, counters and
// emergency latch, and loads check_period = 600 and feed_period = 10.
// Registers at paddr 0 (check_period) and 4 (feed_period) are written
// over APB; the user must write them only while no items are in flight,
// as the block itself does not enforce it.
module heartbeat_mask_supervisor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: component_mask[31:0]
    input  logic [hbms_pkg::MASK_W-1:0]      s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: feed_pulse[0], check_done[1], check_failed[2],
    // missing_mask[34:3], emergency[35], zero[39:36]
    output logic [hbms_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hbms_pkg::ADDR_W-1:0]      paddr,
    input  logic [hbms_pkg::DATA_W-1:0]      pwdata,
    output logic [hbms_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import hbms_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hbms_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.kind           <= kind_t'(s_tuser);
            item_reg.component_mask <= s_tdata;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.emergency, res_reg.missing_mask,
                       res_reg.check_failed, res_reg.check_done,
                       res_reg.feed_pulse};

endmodule

// ----- src/hbms_cfg.sv -----
// APB-style configuration registers for the heartbeat mask supervisor.
// Depends on hbms_pkg.
module hbms_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hbms_pkg::ADDR_W-1:0] paddr,
    input  logic [hbms_pkg::DATA_W-1:0] pwdata,
    output logic [hbms_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hbms_pkg::cfg_t             cfg
);
    import hbms_pkg::*;

    logic [CNT_W-1:0] check_period_reg;
    logic [CNT_W-1:0] feed_period_reg;
    logic             wr_en;
    reg_sel_t         sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_sel_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_period_reg <= CHECK_PERIOD_RST;
            feed_period_reg  <= FEED_PERIOD_RST;
        end else if (wr_en) begin
            unique case (sel)
                REG_CHECK_PERIOD: check_period_reg <= pwdata[CNT_W-1:0];
                REG_FEED_PERIOD:  feed_period_reg  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_CHECK_PERIOD: prdata = {{(DATA_W-CNT_W){1'b0}}, check_period_reg};
            REG_FEED_PERIOD:  prdata = {{(DATA_W-CNT_W){1'b0}}, feed_period_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.check_period = check_period_reg;
    assign cfg.feed_period  = feed_period_reg;

endmodule

// ----- src/hbms_core.sv -----
// Supervisor state (expected and seen sets, emergency latch, elapsed
// counters) and the per-item update logic. Depends on hbms_pkg.
module hbms_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  hbms_pkg::item_t   item,
    input  hbms_pkg::cfg_t    cfg,
    output hbms_pkg::result_t result
);
    import hbms_pkg::*;

    logic [MASK_W-1:0] expected_reg, expected_next;
    logic [MASK_W-1:0] seen_reg, seen_next;
    logic              latch_reg, latch_next;
    logic [CNT_W-1:0]  tsc_reg, tsc_next;
    logic [CNT_W-1:0]  tsf_reg, tsf_next;

    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] missing;
    logic [CNT_W-1:0]  tsc_inc;
    logic [CNT_W-1:0]  tsf_inc;
    logic              do_check;
    logic              failed;
    logic              do_feed;

    always_comb begin
        mask     = item.component_mask & COMP_MASK;
        tsc_inc  = (tsc_reg == {CNT_W{1'b1}}) ? tsc_reg : tsc_reg + CNT_W'(1);
        tsf_inc  = (tsf_reg == {CNT_W{1'b1}}) ? tsf_reg : tsf_reg + CNT_W'(1);
        missing  = expected_reg & ~seen_reg & COMP_MASK;
        do_check = !latch_reg && (tsc_inc >= cfg.check_period);
        failed   = do_check && (missing != '0);
        // The feed sees the latch as the check left it.
        do_feed  = !(latch_reg || failed) && (tsf_inc >= cfg.feed_period);

        expected_next = expected_reg;
        seen_next     = seen_reg;
        latch_next    = latch_reg;
        tsc_next      = tsc_reg;
        tsf_next      = tsf_reg;
        result        = '0;

        case (item.kind)
            KIND_REGISTER: expected_next = expected_reg | mask;
            KIND_REPORT:   seen_next     = seen_reg | mask;
            KIND_ERROR:    latch_next    = 1'b1;
            default: begin
                tsc_next = do_check ? '0 : tsc_inc;
                tsf_next = do_feed  ? '0 : tsf_inc;
                if (do_check) begin
                    seen_next = '0;
                end
                if (failed) begin
                    latch_next = 1'b1;
                end
                result.feed_pulse   = do_feed;
                result.check_done   = do_check;
                result.check_failed = failed;
                result.missing_mask = do_check ? missing : '0;
            end
        endcase
        result.emergency = latch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= '0;
            seen_reg     <= '0;
            latch_reg    <= 1'b0;
            tsc_reg      <= '0;
            tsf_reg      <= '0;
        end else if (advance) begin
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            latch_reg    <= latch_next;
            tsc_reg      <= tsc_next;
            tsf_reg      <= tsf_next;
        end
    end

endmodule
